/* rtl/lhrc_pkg.sv */
package lhrc_pkg;

    // Sizes that the top level hands down
    localparam int KEY_COUNT_DEF = 5;
    localparam int LUX_WIDTH_DEF = 16;

    // Fixed field widths and the key bit offset
    localparam int TH_W       = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int PORT_W     = 8;
    localparam int KEY_BASE   = 3;
    localparam int KEY_IDX_W  = 3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RELAY_ON    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RELAY_OFF   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CURTAIN_ON  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CURTAIN_OFF = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MOTOR_TICKS = 3'd4;

    // Register reset values
    localparam logic [TH_W-1:0] RELAY_ON_RST    = 16'd200;
    localparam logic [TH_W-1:0] RELAY_OFF_RST   = 16'd400;
    localparam logic [TH_W-1:0] CURTAIN_ON_RST  = 16'd100;
    localparam logic [TH_W-1:0] CURTAIN_OFF_RST = 16'd800;
    localparam logic [TH_W-1:0] MOTOR_TICKS_RST = 16'd3000;

    // Item kinds
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_LUX  = 2'd1;
    localparam logic [1:0] MODE_KEY  = 2'd2;

    // Keys with an action
    localparam logic [KEY_IDX_W-1:0] KEY_MANUAL  = 3'd1;
    localparam logic [KEY_IDX_W-1:0] KEY_RELAY   = 3'd3;
    localparam logic [KEY_IDX_W-1:0] KEY_CURTAIN = 3'd4;

    typedef struct packed {
        logic state;
        logic changed;
    } t_hyst_res;

    typedef struct packed {
        logic tick;
        logic start;
    } t_motor_ctl;

endpackage

/* rtl/light_hysteresis_relay_curtain_ctrl.sv */
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+-----------------------------------------
// request   | i_in_valid / o_in_ready     | i_mode, i_lux, i_key_port
// result    | o_out_valid / i_out_ready   | o_relay_on, o_curtain_engaged,
//           |                             | o_motor_dir_a, o_motor_dir_b,
//           |                             | o_manual_mode, o_key_valid, o_key_index
// config    | i_cfg_we                    | i_cfg_addr, i_cfg_wdata
//
// One request per cycle sustained while results are taken as they come; a request's
// result passes through the input register, then the result register.
// Reset (i_rst_n low at a clock edge) clears both stage valids, all control state
// and loads the threshold and run-length registers with their defaults.
// A stalled result holds the result register; the input register still drains
// into it as soon as it is taken, so o_in_ready only drops when both are full.
module light_hysteresis_relay_curtain_ctrl #(
    parameter int KEY_COUNT = lhrc_pkg::KEY_COUNT_DEF,
    parameter int LUX_WIDTH = lhrc_pkg::LUX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_mode,
    input  logic [LUX_WIDTH-1:0]              i_lux,
    input  logic [lhrc_pkg::PORT_W-1:0]       i_key_port,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_relay_on,
    output logic                              o_curtain_engaged,
    output logic                              o_motor_dir_a,
    output logic                              o_motor_dir_b,
    output logic                              o_manual_mode,
    output logic                              o_key_valid,
    output logic [lhrc_pkg::KEY_IDX_W-1:0]    o_key_index,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [lhrc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [lhrc_pkg::TH_W-1:0]         i_cfg_wdata
);

    // Configuration registers
    logic [lhrc_pkg::TH_W-1:0] r_relay_on_th;
    logic [lhrc_pkg::TH_W-1:0] r_relay_off_th;
    logic [lhrc_pkg::TH_W-1:0] r_curtain_on_th;
    logic [lhrc_pkg::TH_W-1:0] r_curtain_off_th;
    logic [lhrc_pkg::TH_W-1:0] r_motor_ticks;

    // Input stage
    logic                        r_in_valid;
    logic [1:0]                  r_mode;
    logic [LUX_WIDTH-1:0]        r_lux;
    logic [lhrc_pkg::PORT_W-1:0] r_key_port;

    // Controller state
    logic                 r_relay;
    logic                 r_curtain;
    logic                 r_manual;
    logic [LUX_WIDTH-1:0] r_last_lux;

    // Result stage
    logic                           r_out_valid;
    logic                           r_res_relay;
    logic                           r_res_curtain;
    logic                           r_res_dir_a;
    logic                           r_res_dir_b;
    logic                           r_res_manual;
    logic                           r_res_key_valid;
    logic [lhrc_pkg::KEY_IDX_W-1:0] r_res_key_index;

    // Next values
    logic                 n_relay;
    logic                 n_curtain;
    logic                 n_manual;
    logic [LUX_WIDTH-1:0] n_last_lux;

    logic                           w_adv;
    logic                           w_is_tick;
    logic                           w_is_lux;
    logic                           w_is_key;
    logic                           w_scan_valid;
    logic [lhrc_pkg::KEY_IDX_W-1:0] w_scan_index;
    logic                           w_press;
    logic                           w_key_manual;
    logic                           w_key_relay;
    logic                           w_key_curtain;
    logic                           w_relay_k;
    logic                           w_curtain_k;
    logic                           w_curtain_chg;
    logic                           w_running;
    lhrc_pkg::t_hyst_res            w_relay_h;
    lhrc_pkg::t_hyst_res            w_curtain_h;
    lhrc_pkg::t_motor_ctl           w_motor_ctl;

    // Advance the input stage into the result stage whenever the result slot is free
    // or being taken this cycle.
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    assign w_is_tick = (r_mode == lhrc_pkg::MODE_TICK);
    assign w_is_lux  = (r_mode == lhrc_pkg::MODE_LUX);
    assign w_is_key  = (r_mode == lhrc_pkg::MODE_KEY);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_on_th    <= lhrc_pkg::RELAY_ON_RST;
            r_relay_off_th   <= lhrc_pkg::RELAY_OFF_RST;
            r_curtain_on_th  <= lhrc_pkg::CURTAIN_ON_RST;
            r_curtain_off_th <= lhrc_pkg::CURTAIN_OFF_RST;
            r_motor_ticks    <= lhrc_pkg::MOTOR_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                lhrc_pkg::REG_RELAY_ON:    r_relay_on_th    <= i_cfg_wdata;
                lhrc_pkg::REG_RELAY_OFF:   r_relay_off_th   <= i_cfg_wdata;
                lhrc_pkg::REG_CURTAIN_ON:  r_curtain_on_th  <= i_cfg_wdata;
                lhrc_pkg::REG_CURTAIN_OFF: r_curtain_off_th <= i_cfg_wdata;
                lhrc_pkg::REG_MOTOR_TICKS: r_motor_ticks    <= i_cfg_wdata;
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_mode     <= i_mode;
            r_lux      <= i_lux;
            r_key_port <= i_key_port;
        end
    end

    // ---------------- key scan ----------------
    lhrc_key_scan #(
        .KEY_COUNT (KEY_COUNT)
    ) u_key_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv && w_is_key),
        .i_port  (r_key_port),
        .o_valid (w_scan_valid),
        .o_index (w_scan_index)
    );

    assign w_press       = w_is_key && w_scan_valid;
    assign w_key_manual  = w_press && (w_scan_index == lhrc_pkg::KEY_MANUAL);
    assign w_key_relay   = w_press && (w_scan_index == lhrc_pkg::KEY_RELAY) && r_manual;
    assign w_key_curtain = w_press && (w_scan_index == lhrc_pkg::KEY_CURTAIN) && r_manual;

    // Key actions come first; comparators then run on the updated light level.
    assign n_last_lux  = w_is_lux ? r_lux : r_last_lux;
    assign n_manual    = r_manual ^ w_key_manual;
    assign w_relay_k   = r_relay ^ w_key_relay;
    assign w_curtain_k = r_curtain ^ w_key_curtain;

    // ---------------- hysteresis comparators ----------------
    lhrc_hyst #(
        .LUX_WIDTH (LUX_WIDTH)
    ) u_relay_hyst (
        .i_state  (w_relay_k),
        .i_lux    (n_last_lux),
        .i_on_th  (r_relay_on_th),
        .i_off_th (r_relay_off_th),
        .o_res    (w_relay_h)
    );

    lhrc_hyst #(
        .LUX_WIDTH (LUX_WIDTH)
    ) u_curtain_hyst (
        .i_state  (w_curtain_k),
        .i_lux    (n_last_lux),
        .i_on_th  (r_curtain_on_th),
        .i_off_th (r_curtain_off_th),
        .o_res    (w_curtain_h)
    );

    // Manual mode freezes both comparators; a double flip still counts as a change.
    assign n_relay       = n_manual ? w_relay_k : w_relay_h.state;
    assign n_curtain     = n_manual ? w_curtain_k : w_curtain_h.state;
    assign w_curtain_chg = w_key_curtain || (!n_manual && w_curtain_h.changed);

    // ---------------- curtain motor ----------------
    assign w_motor_ctl.tick  = w_is_tick;
    assign w_motor_ctl.start = w_curtain_chg;

    lhrc_motor u_motor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_ctl       (w_motor_ctl),
        .i_run_ticks (r_motor_ticks),
        .o_running   (w_running)
    );

    // ---------------- controller state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay    <= 1'b0;
            r_curtain  <= 1'b0;
            r_manual   <= 1'b0;
            r_last_lux <= '0;
        end else if (w_adv) begin
            r_relay    <= n_relay;
            r_curtain  <= n_curtain;
            r_manual   <= n_manual;
            r_last_lux <= n_last_lux;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res_relay     <= n_relay;
            r_res_curtain   <= n_curtain;
            r_res_dir_a     <= w_running && !n_curtain;
            r_res_dir_b     <= w_running && n_curtain;
            r_res_manual    <= n_manual;
            r_res_key_valid <= w_press;
            r_res_key_index <= w_press ? w_scan_index : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_relay_on        = r_res_relay;
    assign o_curtain_engaged = r_res_curtain;
    assign o_motor_dir_a     = r_res_dir_a;
    assign o_motor_dir_b     = r_res_dir_b;
    assign o_manual_mode     = r_res_manual;
    assign o_key_valid       = r_res_key_valid;
    assign o_key_index       = r_res_key_index;

`ifndef SYNTHESIS
    // Motor never drives both directions at once.
    a_motor_dir_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_motor_dir_a && o_motor_dir_b))
        else $error("motor driven in both directions");

    // Key index is zero whenever no press is reported.
    a_key_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_key_valid) |-> (o_key_index == '0))
        else $error("key index set without a press");

    // A result that is not taken holds into the next cycle.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_res_curtain)
            && $stable(r_res_relay)))
        else $error("stalled result lost");

    // Direction b is only driven while the curtain is reported engaged.
    a_dir_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_motor_dir_b) |-> o_curtain_engaged)
        else $error("motor direction disagrees with curtain state");
`endif

endmodule

/* rtl/lhrc_hyst.sv */
module lhrc_hyst #(
    parameter int LUX_WIDTH = lhrc_pkg::LUX_WIDTH_DEF
) (
    input  logic                      i_state,
    input  logic [LUX_WIDTH-1:0]      i_lux,
    input  logic [lhrc_pkg::TH_W-1:0] i_on_th,
    input  logic [lhrc_pkg::TH_W-1:0] i_off_th,
    output lhrc_pkg::t_hyst_res       o_res
);

    localparam int CMP_W = (LUX_WIDTH > lhrc_pkg::TH_W) ? LUX_WIDTH : lhrc_pkg::TH_W;

    logic [CMP_W-1:0] w_lux;
    logic [CMP_W-1:0] w_on;
    logic [CMP_W-1:0] w_off;
    logic             w_fire_on;
    logic             w_mid;
    logic             w_fire_off;

    assign w_lux = CMP_W'(i_lux);
    assign w_on  = CMP_W'(i_on_th);
    assign w_off = CMP_W'(i_off_th);

    // on test first, off test sees its result
    assign w_fire_on  = !i_state && (w_lux < w_on);
    assign w_mid      = i_state | w_fire_on;
    assign w_fire_off = w_mid && (w_lux > w_off);

    assign o_res.state   = w_mid & !w_fire_off;
    assign o_res.changed = w_fire_on | w_fire_off;

endmodule

/* rtl/lhrc_key_scan.sv */
module lhrc_key_scan #(
    parameter int KEY_COUNT = lhrc_pkg::KEY_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [lhrc_pkg::PORT_W-1:0]    i_port,
    output logic                           o_valid,
    output logic [lhrc_pkg::KEY_IDX_W-1:0] o_index
);

    logic [KEY_COUNT-1:0] w_keys;
    logic [KEY_COUNT-1:0] w_fresh;
    logic [KEY_COUNT-1:0] r_hist_one;
    logic [KEY_COUNT-1:0] r_hist_two;

    for (genvar g = 0; g < KEY_COUNT; g++) begin : g_key
        if (g + lhrc_pkg::KEY_BASE < lhrc_pkg::PORT_W) begin : g_port
            assign w_keys[g] = i_port[g + lhrc_pkg::KEY_BASE];
        end else begin : g_none
            assign w_keys[g] = 1'b0;
        end
    end

    // high, low, low: older sample high, previous and current low
    assign w_fresh = ~r_hist_one & r_hist_two & ~w_keys;

    always_comb begin
        o_valid = 1'b0;
        o_index = '0;
        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
            if (w_fresh[i]) begin
                o_valid = 1'b1;
                o_index = lhrc_pkg::KEY_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_one <= '0;
            r_hist_two <= '0;
        end else if (i_en) begin
            r_hist_two <= r_hist_one;
            r_hist_one <= w_keys;
        end
    end

endmodule

/* rtl/lhrc_motor.sv */
module lhrc_motor (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  lhrc_pkg::t_motor_ctl      i_ctl,
    input  logic [lhrc_pkg::TH_W-1:0] i_run_ticks,
    output logic                      o_running
);

    logic                      r_running;
    logic [lhrc_pkg::TH_W-1:0] r_count;
    logic                      n_running;
    logic [lhrc_pkg::TH_W-1:0] n_count;

    always_comb begin
        n_running = r_running;
        n_count   = r_count;
        if (i_ctl.tick && r_running && (r_count != '0)) begin
            n_count = r_count - 1'b1;
        end
        if (i_ctl.start) begin
            n_running = 1'b1;
            n_count   = i_run_ticks;
        end
        if (n_running && (n_count == '0)) begin
            n_running = 1'b0;
        end
    end

    assign o_running = n_running;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_count   <= '0;
        end else if (i_en) begin
            r_running <= n_running;
            r_count   <= n_count;
        end
    end

endmodule

/* test/tb_light_hysteresis_relay_curtain_ctrl.sv */
`timescale 1ns / 100ps

module tb_light_hysteresis_relay_curtain_ctrl;

    // Item kind that the block takes in without any effect
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Keys that are reported but have no action
    localparam logic [lhrc_pkg::KEY_IDX_W-1:0] KEY_PLAIN_LO  = 3'd0;
    localparam logic [lhrc_pkg::KEY_IDX_W-1:0] KEY_PLAIN_MID = 3'd2;

    localparam int KEYS         = lhrc_pkg::KEY_COUNT_DEF;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 4;     // input register plus result register, with margin
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 62;

    // One expected result, laid out in port order
    typedef struct packed {
        logic                           relay_on;
        logic                           curtain_engaged;
        logic                           motor_dir_a;
        logic                           motor_dir_b;
        logic                           manual_mode;
        logic                           key_valid;
        logic [lhrc_pkg::KEY_IDX_W-1:0] key_index;
    } t_drive;

    // Drive every input to a known value from time zero
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic [1:0]                      i_mode      = lhrc_pkg::MODE_TICK;
    logic [15:0]                     i_lux       = '0;
    logic [lhrc_pkg::PORT_W-1:0]     i_key_port  = '1;
    logic                            i_out_ready = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [lhrc_pkg::CFG_ADDR_W-1:0] i_cfg_addr  = lhrc_pkg::REG_RELAY_ON;
    logic [lhrc_pkg::TH_W-1:0]       i_cfg_wdata = '0;

    logic                            o_in_ready;
    logic                            o_out_valid;
    logic                            o_relay_on;
    logic                            o_curtain_engaged;
    logic                            o_motor_dir_a;
    logic                            o_motor_dir_b;
    logic                            o_manual_mode;
    logic                            o_key_valid;
    logic [lhrc_pkg::KEY_IDX_W-1:0]  o_key_index;

    light_hysteresis_relay_curtain_ctrl u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_lux             (i_lux),
        .i_key_port        (i_key_port),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_relay_on        (o_relay_on),
        .o_curtain_engaged (o_curtain_engaged),
        .o_motor_dir_a     (o_motor_dir_a),
        .o_motor_dir_b     (o_motor_dir_b),
        .o_manual_mode     (o_manual_mode),
        .o_key_valid       (o_key_valid),
        .o_key_index       (o_key_index),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Controller copy: registers as last written, and the control state
    // ------------------------------------------------------------------
    logic [lhrc_pkg::TH_W-1:0] reg_shadow [5];

    logic                      ctl_relay      = 1'b0;
    logic                      ctl_curtain    = 1'b0;
    logic                      ctl_manual     = 1'b0;
    logic [15:0]               ctl_level      = '0;
    logic [KEYS-1:0]           ctl_hist_one   = '0;
    logic [KEYS-1:0]           ctl_hist_two   = '0;
    logic                      ctl_motor_on   = 1'b0;
    logic [lhrc_pkg::TH_W-1:0] ctl_motor_left = '0;

    t_drive pending_drive[$];   // results still owed by the block, oldest first

    int idle_pct       = 0;     // chance in percent that either side idles
    int stall_left     = 0;
    int quiet_cycles   = 0;
    int fault_count    = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int register_loads = 0;
    int presses_seen   = 0;
    int manual_toggles = 0;
    int motor_starts   = 0;
    int motor_stops    = 0;

    // Mostly no gap, mostly short when there is one, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(12, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [KEYS-1:0] key_bit(input logic [lhrc_pkg::KEY_IDX_W-1:0] idx);
        return KEYS'(1) << idx;
    endfunction

    // Advance the controller copy by one request and return what the block
    // must report for it
    function automatic t_drive step_controller(input logic [1:0]                  kind,
                                               input logic [15:0]                 lux,
                                               input logic [lhrc_pkg::PORT_W-1:0] port);
        t_drive          res;
        logic [KEYS-1:0] keys;
        logic [KEYS-1:0] fresh;
        logic            moved;

        res   = '0;
        moved = 1'b0;

        case (kind)
            lhrc_pkg::MODE_TICK: begin
                if (ctl_motor_on && ctl_motor_left != 0)
                    ctl_motor_left = ctl_motor_left - 1'b1;
            end
            lhrc_pkg::MODE_LUX: begin
                ctl_level = lux;
            end
            lhrc_pkg::MODE_KEY: begin
                // A press is high two samples back, then low, then low now
                keys  = port[lhrc_pkg::KEY_BASE +: KEYS];
                fresh = ~ctl_hist_one & ctl_hist_two & ~keys;
                // Scan downward so the lowest pressed key is the one left standing
                for (int i = KEYS - 1; i >= 0; i--) begin
                    if (fresh[i]) begin
                        res.key_valid = 1'b1;
                        res.key_index = lhrc_pkg::KEY_IDX_W'(i);
                    end
                end
                ctl_hist_two = ctl_hist_one;
                ctl_hist_one = keys;
                if (res.key_valid) begin
                    presses_seen++;
                    if (res.key_index == lhrc_pkg::KEY_MANUAL) begin
                        ctl_manual = ~ctl_manual;
                        manual_toggles++;
                    end else if (res.key_index == lhrc_pkg::KEY_RELAY && ctl_manual) begin
                        ctl_relay = ~ctl_relay;
                    end else if (res.key_index == lhrc_pkg::KEY_CURTAIN && ctl_manual) begin
                        ctl_curtain = ~ctl_curtain;
                        moved       = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // Automatic mode: on test first, then off test, so both may fire
        if (!ctl_manual) begin
            if (!ctl_relay && ctl_level < reg_shadow[lhrc_pkg::REG_RELAY_ON])
                ctl_relay = 1'b1;
            if (ctl_relay && ctl_level > reg_shadow[lhrc_pkg::REG_RELAY_OFF])
                ctl_relay = 1'b0;
            if (!ctl_curtain && ctl_level < reg_shadow[lhrc_pkg::REG_CURTAIN_ON]) begin
                ctl_curtain = 1'b1;
                moved       = 1'b1;
            end
            if (ctl_curtain && ctl_level > reg_shadow[lhrc_pkg::REG_CURTAIN_OFF]) begin
                ctl_curtain = 1'b0;
                moved       = 1'b1;
            end
        end

        // Restart the motor on any curtain change, then stop it once the count is spent
        if (moved) begin
            ctl_motor_on   = 1'b1;
            ctl_motor_left = reg_shadow[lhrc_pkg::REG_MOTOR_TICKS];
            motor_starts++;
        end
        if (ctl_motor_on && ctl_motor_left == 0) begin
            ctl_motor_on = 1'b0;
            motor_stops++;
        end

        res.relay_on        = ctl_relay;
        res.curtain_engaged = ctl_curtain;
        res.motor_dir_a     = ctl_motor_on && !ctl_curtain;
        res.motor_dir_b     = ctl_motor_on && ctl_curtain;
        res.manual_mode     = ctl_manual;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. Valid is only
    // dropped when a gap comes first, so back-to-back requests keep it high.
    task automatic send_request(input logic [1:0]                  kind,
                                input logic [15:0]                 lux,
                                input logic [lhrc_pkg::PORT_W-1:0] port);
        int gap;

        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= kind;
        i_lux      <= lux;
        i_key_port <= port;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_drive.push_back(step_controller(kind, lux, port));
        requests_sent++;
    endtask

    // One clean press: all keys released, then the mask held low for two samples.
    // The unused low port bits and the ignored lux field stay random.
    task automatic press_key(input logic [KEYS-1:0] mask);
        send_request(lhrc_pkg::MODE_KEY, 16'($urandom_range(0, 16'hFFFF)),
                     {{KEYS{1'b1}}, 3'b000} | lhrc_pkg::PORT_W'($urandom_range(0, 7)));
        repeat (2)
            send_request(lhrc_pkg::MODE_KEY, 16'($urandom_range(0, 16'hFFFF)),
                         {~mask, 3'b000} | lhrc_pkg::PORT_W'($urandom_range(0, 7)));
    endtask

    // Stop offering and let every owed result come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all five registers back to back; call only with the block idle
    task automatic load_registers(input logic [lhrc_pkg::TH_W-1:0] relay_on_th,
                                  input logic [lhrc_pkg::TH_W-1:0] relay_off_th,
                                  input logic [lhrc_pkg::TH_W-1:0] curtain_on_th,
                                  input logic [lhrc_pkg::TH_W-1:0] curtain_off_th,
                                  input logic [lhrc_pkg::TH_W-1:0] run_ticks);
        logic [lhrc_pkg::TH_W-1:0] vals [5];

        vals[lhrc_pkg::REG_RELAY_ON]    = relay_on_th;
        vals[lhrc_pkg::REG_RELAY_OFF]   = relay_off_th;
        vals[lhrc_pkg::REG_CURTAIN_ON]  = curtain_on_th;
        vals[lhrc_pkg::REG_CURTAIN_OFF] = curtain_off_th;
        vals[lhrc_pkg::REG_MOTOR_TICKS] = run_ticks;
        for (int r = lhrc_pkg::REG_RELAY_ON; r <= lhrc_pkg::REG_MOTOR_TICKS; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= lhrc_pkg::CFG_ADDR_W'(r);
            i_cfg_wdata <= vals[lhrc_pkg::CFG_ADDR_W'(r)];
            @(posedge i_clk);
            reg_shadow[lhrc_pkg::CFG_ADDR_W'(r)] = vals[lhrc_pkg::CFG_ADDR_W'(r)];
        end
        i_cfg_we <= 1'b0;
        register_loads++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, checking, watchdog
    // ------------------------------------------------------------------

    // Hold ready low for a picked number of cycles after each high cycle
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            stall_left  <= pick_gap();
        end
    end

    always @(posedge i_clk) begin : check_results
        t_drive got;
        t_drive want;

        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_relay_on, o_curtain_engaged, o_motor_dir_a, o_motor_dir_b,
                   o_manual_mode, o_key_valid, o_key_index};
            results_seen++;
            if (pending_drive.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("result %0d arrived with nothing owed: %p", results_seen, got);
            end else begin
                want = pending_drive.pop_front();
                if (got !== want) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"result %0d mismatch (relay curtain dir_a dir_b manual",
                                  " key_valid key_index): expected %b %b %b %b %b %b %0d,",
                                  " got %b %b %b %b %b %b %0d"},
                                 results_seen,
                                 want.relay_on, want.curtain_engaged, want.motor_dir_a,
                                 want.motor_dir_b, want.manual_mode, want.key_valid,
                                 want.key_index,
                                 got.relay_on, got.curtain_engaged, got.motor_dir_a,
                                 got.motor_dir_b, got.manual_mode, got.key_valid,
                                 got.key_index);
                end
            end
        end
    end

    // Give up when neither channel has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results still owed",
                     quiet_cycles, pending_drive.size());
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset thresholds: light extremes, the strict edge of the relay on test,
    // a tick and the unused item kind
    task automatic test_light_levels();
        idle_pct = 25;
        send_request(lhrc_pkg::MODE_LUX, 16'h0000, 8'h00);   // dark: relay on, curtain engages
        send_request(lhrc_pkg::MODE_TICK, 16'hFFFF, 8'hFF);  // count down a running motor
        send_request(lhrc_pkg::MODE_LUX, 16'hFFFF, 8'hFF);   // bright: both release
        send_request(MODE_UNUSED, 16'hFFFF, 8'hFF);          // take nothing in
        send_request(lhrc_pkg::MODE_LUX, lhrc_pkg::RELAY_ON_RST, 8'h00); // at threshold
        send_request(lhrc_pkg::MODE_LUX, lhrc_pkg::RELAY_ON_RST - 1'b1, 8'h00);
    endtask

    // Manual mode on, relay and curtain by key, lowest key wins, manual off
    task automatic test_keys();
        press_key(key_bit(lhrc_pkg::KEY_MANUAL));
        press_key(key_bit(lhrc_pkg::KEY_RELAY));
        press_key(key_bit(lhrc_pkg::KEY_CURTAIN));
        press_key(key_bit(KEY_PLAIN_LO) | key_bit(KEY_PLAIN_MID)
                  | key_bit(lhrc_pkg::KEY_CURTAIN));
        press_key(key_bit(lhrc_pkg::KEY_MANUAL));
    endtask

    // Zero run length with both comparators flipping twice in one pass, then a
    // two-tick run counted down to a stop
    task automatic test_motor_run();
        drain_results();
        load_registers(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        send_request(lhrc_pkg::MODE_TICK, 16'h0000, 8'h00);
        send_request(lhrc_pkg::MODE_LUX, 16'd300, 8'h00);
        drain_results();
        load_registers(lhrc_pkg::RELAY_ON_RST, lhrc_pkg::RELAY_OFF_RST,
                       lhrc_pkg::CURTAIN_ON_RST, lhrc_pkg::CURTAIN_OFF_RST, 16'd2);
        send_request(lhrc_pkg::MODE_LUX, 16'h0000, 8'h00);
        repeat (2) send_request(lhrc_pkg::MODE_TICK, 16'h0000, 8'h00);
    endtask

    // Several register settings, each with a stream of mostly well-formed
    // traffic: ticks, light near the thresholds and clean key presses, with
    // raw key noise and unused items mixed in
    task automatic test_random_traffic();
        int                        phase_items;
        int                        pick;
        logic [lhrc_pkg::TH_W-1:0] lo;
        logic [lhrc_pkg::TH_W-1:0] hi;
        logic [15:0]               level;

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: load_registers(lhrc_pkg::RELAY_ON_RST, lhrc_pkg::RELAY_OFF_RST,
                                  lhrc_pkg::CURTAIN_ON_RST, lhrc_pkg::CURTAIN_OFF_RST,
                                  lhrc_pkg::MOTOR_TICKS_RST);
                1: load_registers('0, '0, '0, '0, '0);
                2: load_registers('1, '1, '1, '1, '1);
                3: begin
                    // on above off: a level in between flips twice per pass
                    lo = 16'($urandom_range(0, 1500));
                    hi = lo + 16'($urandom_range(1, 1500));
                    load_registers(hi, lo, hi, lo, 16'($urandom_range(0, 6)));
                end
                default: begin
                    lo = 16'($urandom_range(0, 2000));
                    hi = lo + 16'($urandom_range(0, 2000));
                    load_registers(lo, hi, lo + 16'($urandom_range(0, 300)),
                                   hi - 16'($urandom_range(0, 300)),
                                   16'($urandom_range(0, 12)));
                end
            endcase
            // every fourth phase runs with no idling at all
            idle_pct = (phase % 4 == 0) ? 0 : $urandom_range(10, 60);

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    send_request(lhrc_pkg::MODE_TICK, 16'($urandom_range(0, 16'hFFFF)),
                                 lhrc_pkg::PORT_W'($urandom_range(0, 255)));
                    phase_items++;
                end else if (pick < 50) begin
                    if ($urandom_range(0, 2) == 0)
                        level = 16'($urandom_range(0, 16'hFFFF));
                    else
                        level = reg_shadow[lhrc_pkg::CFG_ADDR_W'($urandom_range(0, 3))]
                                + 16'($urandom_range(0, 2)) - 16'd1;
                    send_request(lhrc_pkg::MODE_LUX, level,
                                 lhrc_pkg::PORT_W'($urandom_range(0, 255)));
                    phase_items++;
                end else if (pick < 85) begin
                    if ($urandom_range(0, 9) < 7)
                        press_key(key_bit(lhrc_pkg::KEY_IDX_W'($urandom_range(0, KEYS - 1))));
                    else
                        press_key(KEYS'($urandom_range(1, (1 << KEYS) - 1)));
                    phase_items += 3;
                end else if (pick < 95) begin
                    send_request(lhrc_pkg::MODE_KEY, 16'($urandom_range(0, 16'hFFFF)),
                                 lhrc_pkg::PORT_W'($urandom_range(0, 255)));
                    phase_items++;
                end else begin
                    send_request(MODE_UNUSED, 16'($urandom_range(0, 16'hFFFF)),
                                 lhrc_pkg::PORT_W'($urandom_range(0, 255)));
                    phase_items++;
                end
            end
        end
    endtask

    initial begin : run_tests
        reg_shadow[lhrc_pkg::REG_RELAY_ON]    = lhrc_pkg::RELAY_ON_RST;
        reg_shadow[lhrc_pkg::REG_RELAY_OFF]   = lhrc_pkg::RELAY_OFF_RST;
        reg_shadow[lhrc_pkg::REG_CURTAIN_ON]  = lhrc_pkg::CURTAIN_ON_RST;
        reg_shadow[lhrc_pkg::REG_CURTAIN_OFF] = lhrc_pkg::CURTAIN_OFF_RST;
        reg_shadow[lhrc_pkg::REG_MOTOR_TICKS] = lhrc_pkg::MOTOR_TICKS_RST;

        // Hold reset low from time zero, then release it for good
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_light_levels();
        test_keys();
        test_motor_run();
        test_random_traffic();
        drain_results();

        $display("summary: %0d requests, %0d results checked, %0d register loads",
                 requests_sent, results_seen, register_loads);
        $display("summary: %0d key presses, %0d manual toggles, %0d motor starts, %0d stops",
                 presses_seen, manual_toggles, motor_starts, motor_stops);
        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", fault_count);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* light_hysteresis_relay_curtain_ctrl.f */
rtl/lhrc_pkg.sv
rtl/lhrc_hyst.sv
rtl/lhrc_key_scan.sv
rtl/lhrc_motor.sv
rtl/light_hysteresis_relay_curtain_ctrl.sv
test/tb_light_hysteresis_relay_curtain_ctrl.sv
